// ----- rtl/core/lpam_pkg.sv -----
package lpam_pkg;

    typedef enum logic [2:0] {
        ACT_WR_CUR  = 3'd0,
        ACT_WR_BEST = 3'd1,
        ACT_FT_CUR  = 3'd2,
        ACT_FT_BEST = 3'd3,
        ACT_REWARD  = 3'd4,
        ACT_SET_RET = 3'd5,
        ACT_RESTART = 3'd6,
        ACT_NOP     = 3'd7
    } act_t;

    localparam logic [1:0] CFG_EVAL_EPISODES = 2'd0;
    localparam logic [1:0] CFG_TIE_EPSILON   = 2'd1;
    localparam logic [1:0] CFG_RANDOM_SEED   = 2'd2;

    localparam logic [15:0] LFSR_TAPS = 16'hB400;
    localparam int RET_W = 48;

    typedef struct packed {
        logic [2:0]         action;
        logic [9:0]         slot;
        logic signed [15:0] element;
        logic               last_feature;
        logic signed [31:0] signed_amount;
        logic               terminal;
    } in_item_t;

    typedef struct packed {
        logic [3:0] chosen_action;
        logic       choice_made;
        logic       best_replaced;
        logic       reload_weights;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_COPY,
        ST_CLEAR,
        ST_DONE
    } state_t;

endpackage

// ----- rtl/core/linear_policy_argmax_with_best_keep.sv -----
// Linear action scorer with tie-broken argmax and best-weight keeping.
// Input items arrive on in_item with in_valid/in_stall; each yields exactly one
// result item on out_item with out_valid/out_stall. Configuration is written
// through cfg_we, cfg_index and cfg_data; the user must do so only while the
// block is idle, which the block itself does not enforce. Weight writes,
// rewards and other simple items pass the read and done states before their
// result is registered, and the next item is accepted in the cycle after the
// result is taken. A last feature item scores every action: one
// multiply-accumulate per cycle through a single shared multiplier. An
// evaluation end with a new best copies the current table into the best table
// one entry a cycle. After reset both weight tables are cleared by a pass that
// writes zero to one entry a cycle, during which no item is accepted. The best
// return starts at the most negative value, the LFSR at 1. The result is held
// in an output register; while the receiver stalls the block finishes no
// further item, and one item is worked on at a time.
module linear_policy_argmax_with_best_keep
    import lpam_pkg::*;
#(
    parameter int NUM_FEATURES = 8,
    parameter int NUM_ACTIONS  = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_item,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_item,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data
);

    localparam int TSIZE = NUM_ACTIONS * NUM_FEATURES;
    localparam int TW = (TSIZE > 1) ? $clog2(TSIZE) : 1;
    localparam int FW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
    localparam int CW = $clog2(TSIZE + 1);
    localparam logic signed [RET_W-1:0] RET_MAX = {1'b0, {(RET_W-1){1'b1}}};
    localparam logic signed [RET_W-1:0] RET_MIN = {1'b1, {(RET_W-1){1'b0}}};

    logic [15:0] cur_mem [TSIZE];
    logic [15:0] best_mem [TSIZE];
    logic [15:0] feat_reg [NUM_FEATURES];

    logic [15:0] eval_episodes_reg, tie_epsilon_reg, lfsr_reg, lfsr_next;
    logic signed [RET_W-1:0] ep_ret_reg, ep_ret_next, best_ret_reg, best_ret_next;
    logic [15:0] seen_reg, seen_next;

    state_t state_reg, state_next;
    in_item_t item_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic out_valid_reg;
    out_item_t out_reg;
    logic replaced_reg, replaced_next, reload_reg, reload_next;

    logic [15:0] cur_rd_reg, best_rd_reg;
    logic [15:0] feat_rd_reg;
    logic rd_ok_reg;
    logic signed [31:0] prod_reg;
    logic prod_ok_reg, prod_last_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] bscore_reg;
    logic [3:0] bidx_reg, act_cnt_reg;
    logic [16:0] ties_reg;

    logic in_acc;
    logic [TW-1:0] rd_addr;
    logic [FW-1:0] col_reg;
    logic feat_we, feat_fwd;
    logic cur_we, best_we;
    logic [TW-1:0] cur_wa, best_wa;
    logic [15:0] cur_wd, best_wd;

    assign in_acc = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item = out_reg;
    assign rd_addr = cnt_reg[TW-1:0];
    assign feat_we = state_reg == ST_READ
                     && (item_reg.action == ACT_FT_CUR || item_reg.action == ACT_FT_BEST)
                     && 32'(item_reg.slot) < NUM_FEATURES;
    assign feat_fwd = feat_we && item_reg.slot[FW-1:0] == col_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (cnt_reg == CW'(TSIZE - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (in_acc) state_next = ST_READ;
            ST_READ:
            begin
                if ((item_reg.action == ACT_FT_CUR || item_reg.action == ACT_FT_BEST)
                    && item_reg.last_feature)
                    state_next = ST_MAC;
                else if (replaced_next)
                    state_next = ST_COPY;
                else
                    state_next = ST_DONE;
            end
            ST_MAC:   if (prod_ok_reg && prod_last_reg && !rd_ok_reg) state_next = ST_DONE;
            ST_COPY:  if (rd_ok_reg && cnt_reg == CW'(TSIZE)) state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Reward bookkeeping is evaluated in ST_READ.
    logic signed [RET_W:0] sum_w;
    always_comb
    begin
        ep_ret_next = ep_ret_reg;
        best_ret_next = best_ret_reg;
        seen_next = seen_reg;
        replaced_next = 1'b0;
        reload_next = 1'b0;
        sum_w = {ep_ret_reg[RET_W-1], ep_ret_reg}
              + (RET_W+1)'(signed'(item_reg.signed_amount));
        if (state_reg == ST_READ)
        begin
            unique case (item_reg.action)
                ACT_REWARD:
                begin
                    if (sum_w > (RET_W+1)'(RET_MAX)) ep_ret_next = RET_MAX;
                    else if (sum_w < (RET_W+1)'(RET_MIN)) ep_ret_next = RET_MIN;
                    else ep_ret_next = sum_w[RET_W-1:0];
                    if (item_reg.terminal)
                    begin
                        seen_next = seen_reg + 16'd1;
                        if (seen_next == eval_episodes_reg)
                        begin
                            if (ep_ret_next > best_ret_reg)
                            begin
                                best_ret_next = ep_ret_next;
                                replaced_next = 1'b1;
                            end
                            ep_ret_next = '0;
                            seen_next = '0;
                            reload_next = 1'b1;
                        end
                    end
                end
                ACT_SET_RET: best_ret_next = RET_W'(signed'(item_reg.signed_amount));
                ACT_RESTART:
                begin
                    ep_ret_next = '0;
                    seen_next = '0;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cur_we = 1'b0;
        best_we = 1'b0;
        cur_wa = item_reg.slot[TW-1:0];
        best_wa = item_reg.slot[TW-1:0];
        cur_wd = item_reg.element;
        best_wd = item_reg.element;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cur_we = 1'b1;
                best_we = 1'b1;
                cur_wa = rd_addr;
                best_wa = rd_addr;
                cur_wd = '0;
                best_wd = '0;
            end
            ST_READ:
            begin
                cur_we = item_reg.action == ACT_WR_CUR && 32'(item_reg.slot) < TSIZE;
                best_we = item_reg.action == ACT_WR_BEST && 32'(item_reg.slot) < TSIZE;
            end
            ST_COPY:
            begin
                best_we = rd_ok_reg;
                best_wa = TW'(cnt_reg - CW'(1));
                best_wd = cur_rd_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cur_we) cur_mem[cur_wa] <= cur_wd;
        if (best_we) best_mem[best_wa] <= best_wd;
        cur_rd_reg <= cur_mem[rd_addr];
        best_rd_reg <= best_mem[rd_addr];
        feat_rd_reg <= feat_fwd ? item_reg.element : feat_reg[col_reg];
        if (feat_we)
            feat_reg[item_reg.slot[FW-1:0]] <= item_reg.element;
        if (in_acc) item_reg <= in_item;
        prod_reg <= signed'(feat_rd_reg)
                  * signed'(item_reg.action == ACT_FT_CUR ? cur_rd_reg : best_rd_reg);
    end

    // Scoring: a read in flight, then a product, then accumulate and compare.
    logic signed [63:0] acc_sum, diff, adiff;
    logic [15:0] lfsr_step;
    logic [32:0] draw_prod;
    logic row_end;
    assign acc_sum = acc_reg + 64'(prod_reg);
    assign diff = acc_sum - bscore_reg;
    assign adiff = diff[63] ? -diff : diff;
    assign lfsr_step = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_TAPS) : (lfsr_reg >> 1);
    assign draw_prod = 33'(lfsr_step) * 33'(ties_reg + 17'd2);
    assign row_end = prod_ok_reg && (prod_last_reg
                     || (col_reg == FW'(1 % NUM_FEATURES) && rd_ok_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg <= '0;
            col_reg <= '0;
            out_valid_reg <= 1'b0;
            out_reg <= '0;
            eval_episodes_reg <= 16'd1;
            tie_epsilon_reg <= 16'd1;
            lfsr_reg <= 16'd1;
            ep_ret_reg <= '0;
            best_ret_reg <= RET_MIN;
            seen_reg <= '0;
            rd_ok_reg <= 1'b0;
            prod_ok_reg <= 1'b0;
            prod_last_reg <= 1'b0;
            acc_reg <= '0;
            bscore_reg <= '0;
            bidx_reg <= '0;
            act_cnt_reg <= '0;
            ties_reg <= '0;
            replaced_reg <= 1'b0;
            reload_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ep_ret_reg <= ep_ret_next;
            best_ret_reg <= best_ret_next;
            seen_reg <= seen_next;
            lfsr_reg <= lfsr_next;
            if (out_valid_reg && !out_stall) out_valid_reg <= 1'b0;
            if (cfg_we && cfg_index == CFG_EVAL_EPISODES) eval_episodes_reg <= cfg_data;
            if (cfg_we && cfg_index == CFG_TIE_EPSILON) tie_epsilon_reg <= cfg_data;
            rd_ok_reg <= (state_reg == ST_READ && state_next != ST_DONE)
                         || ((state_reg == ST_MAC || state_reg == ST_COPY)
                             && rd_ok_reg && cnt_reg != CW'(TSIZE));
            prod_ok_reg <= rd_ok_reg && state_reg == ST_MAC;
            prod_last_reg <= rd_ok_reg && cnt_reg == CW'(TSIZE);
            unique case (state_reg)
                ST_CLEAR: cnt_reg <= cnt_reg + CW'(1);
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    col_reg <= '0;
                end
                ST_READ:
                begin
                    replaced_reg <= replaced_next;
                    reload_reg <= reload_next;
                    acc_reg <= '0;
                    act_cnt_reg <= '0;
                    bidx_reg <= '0;
                    ties_reg <= '0;
                    cnt_reg <= (state_next != ST_DONE) ? CW'(1) : '0;
                    col_reg <= (state_next != ST_DONE) ? FW'(1 % NUM_FEATURES) : '0;
                end
                ST_MAC, ST_COPY:
                begin
                    if (rd_ok_reg && cnt_reg != CW'(TSIZE))
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                        col_reg <= (col_reg == FW'(NUM_FEATURES - 1)) ? '0
                                   : col_reg + FW'(1);
                    end
                    if (state_reg == ST_MAC && prod_ok_reg)
                    begin
                        if (row_end)
                        begin
                            acc_reg <= '0;
                            act_cnt_reg <= act_cnt_reg + 4'd1;
                            if (act_cnt_reg == 4'd0)
                                bscore_reg <= acc_sum;
                            else if (adiff < 64'(tie_epsilon_reg))
                            begin
                                ties_reg <= ties_reg + 17'd1;
                                if (draw_prod < 33'd65536)
                                begin
                                    bscore_reg <= acc_sum;
                                    bidx_reg <= act_cnt_reg;
                                end
                            end
                            else if (acc_sum > bscore_reg)
                            begin
                                bscore_reg <= acc_sum;
                                bidx_reg <= act_cnt_reg;
                                ties_reg <= '0;
                            end
                        end
                        else
                            acc_reg <= acc_sum;
                    end
                end
                ST_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    out_reg.choice_made <= (item_reg.action == ACT_FT_CUR
                        || item_reg.action == ACT_FT_BEST) && item_reg.last_feature;
                    out_reg.chosen_action <= ((item_reg.action == ACT_FT_CUR
                        || item_reg.action == ACT_FT_BEST) && item_reg.last_feature)
                        ? bidx_reg : 4'd0;
                    out_reg.best_replaced <= replaced_reg;
                    out_reg.reload_weights <= reload_reg;
                end
                default: ;
            endcase
        end
    end

    logic tie_step;
    assign tie_step = state_reg == ST_MAC && prod_ok_reg && row_end
                      && act_cnt_reg != 4'd0 && adiff < 64'(tie_epsilon_reg);

    always_comb
    begin
        lfsr_next = lfsr_reg;
        if (cfg_we && cfg_index == CFG_RANDOM_SEED)
            lfsr_next = (cfg_data == 16'd0) ? 16'd1 : cfg_data;
        else if (tie_step)
            lfsr_next = lfsr_step;
    end

    assert property (@(posedge clk) disable iff (!rst_n) lfsr_reg != 16'd0)
        else $error("tie LFSR reached zero");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg == ST_READ)
        else $error("accepted item not started");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("stalled result dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == ST_IDLE)
        else $error("result shown while busy");

endmodule
